### rtl/pli_pkg.sv
// shared constants, types and codes of the positional list unit
package pli_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int POS_W      = 7;
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int GRP_W      = 8;
    localparam int GRP_N      = (CAPACITY + GRP_W - 1) / GRP_W;
    localparam int GRP_IW     = $clog2(GRP_W);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [31:0]           t_word;
    typedef logic [POS_W-1:0]             t_pos;
    typedef logic [CNT_W-1:0]             t_cnt;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CMP_W-1:0]             t_cmp;
    typedef logic [GRP_IW-1:0]            t_gidx;

    typedef enum logic [1:0] {
        FN_DISPLAY = 2'd0,
        FN_INSERT  = 2'd1,
        FN_DELETE  = 2'd2,
        FN_SEARCH  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp;
    } t_cell_ctl;

    typedef struct packed {
        t_func func;
        t_pos  position;
        t_word new_value;
        t_word search_key;
    } t_in_word;

    typedef struct packed {
        t_status status;
        t_word   element;
        t_pos    found_at;
        t_pos    entry_count;
        logic    last;
    } t_out_word;

endpackage

### rtl/positional_list_insert_delete_search_unit.sv
// top level of the positional list unit: cell chain, match encoder and request sequencer
//
// usage
//   requests arrive on the input channel (i_in_valid / o_in_ready, word i_in_word);
//   results leave on the output channel (o_out_valid / i_out_ready, word o_out_word)
//   from a single output register, the last result of a request carries last = 1
//   the list lives in a row of cells, one entry per cell; each cell can take the
//   word of its left or right neighbour, load a new word or hold
//   insert and delete: the cells from the position on shift at the accepting edge, the
//     result is written to the output register at that same edge
//   search: cells compare in parallel, then a two-stage first-match encoder picks the
//     lowest hit; the result is written from S_SRCH3 once the output register is free
//   display: the first count cells rotate by one per emitted word, cell 0 feeding
//     the output, so the list is back in place after the last word; one entry per
//     cycle unless stalled; count words (one with status empty for an empty list)
//   a request is only taken while no other is in flight and the output register
//   is free or being drained that cycle, so a stalled receiver simply holds the
//   sequencer; nothing is dropped
//   reset (synchronous, active low) empties the list and clears the output valid;
//   cell contents are not cleared, only entries below the count are ever read
module positional_list_insert_delete_search_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pli_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pli_pkg::t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH1,
        S_SRCH2,
        S_SRCH3,
        S_DISP
    } t_state;

    // whole-list operation applied to the chain in a cycle
    typedef enum logic [2:0] {
        L_NONE,
        L_INS,
        L_DEL,
        L_ROT,
        L_CMP
    } t_list_op;

    t_state             r_state,     n_state;
    pli_pkg::t_cnt      r_count,     n_count;
    pli_pkg::t_cnt      r_left,      n_left;
    logic               r_out_valid, n_out_valid;
    pli_pkg::t_out_word r_out,       n_out;

    t_list_op           w_lop;
    logic               w_out_free;
    logic               w_accept;
    logic               w_emit;
    pli_pkg::t_cmp      w_pos;
    pli_pkg::t_cmp      w_cnt;
    logic               w_ins_bad;
    logic               w_del_bad;
    logic               w_full;
    pli_pkg::t_data     w_load;
    pli_pkg::t_data     w_key;
    pli_pkg::t_cell_ctl w_ctl  [pli_pkg::CAPACITY];
    pli_pkg::t_data     w_data [pli_pkg::CAPACITY];
    logic [pli_pkg::CAPACITY-1:0] w_match;
    logic               w_found;
    pli_pkg::t_idx      w_found_idx;

    // handshake
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // position checks against the current count
    assign w_pos     = pli_pkg::t_cmp'(i_in_word.position);
    assign w_cnt     = pli_pkg::t_cmp'(r_count);
    assign w_ins_bad = (w_pos == '0) || (w_pos > w_cnt + pli_pkg::t_cmp'(1));
    assign w_del_bad = (w_pos == '0) || (w_pos > w_cnt);
    assign w_full    = (r_count == pli_pkg::t_cnt'(pli_pkg::CAPACITY));

    // rotation wraps cell 0 round to the last occupied cell
    assign w_load = (w_lop == L_ROT) ? w_data[0] : pli_pkg::t_data'(i_in_word.new_value);
    assign w_key  = pli_pkg::t_data'(i_in_word.search_key);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        w_lop       = L_NONE;
        w_emit      = 1'b0;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out.element  = '0;
                    n_out.found_at = '0;
                    n_out.last     = 1'b1;
                    n_out.status   = pli_pkg::ST_OK;
                    case (i_in_word.func)
                        pli_pkg::FN_DISPLAY: begin
                            w_emit = 1'b1;
                            if (r_count == '0) begin
                                n_out.status = pli_pkg::ST_EMPTY;
                            end else begin
                                w_lop         = L_ROT;
                                n_out.element = pli_pkg::t_word'(w_data[0]);
                                n_left        = r_count - pli_pkg::t_cnt'(1);
                                if (r_count != pli_pkg::t_cnt'(1)) begin
                                    n_out.last = 1'b0;
                                    n_state    = S_DISP;
                                end
                            end
                        end
                        pli_pkg::FN_INSERT: begin
                            w_emit = 1'b1;
                            if (w_ins_bad) begin
                                n_out.status = pli_pkg::ST_BAD_POS;
                            end else if (w_full) begin
                                n_out.status = pli_pkg::ST_FULL;
                            end else begin
                                w_lop   = L_INS;
                                n_count = r_count + pli_pkg::t_cnt'(1);
                            end
                        end
                        pli_pkg::FN_DELETE: begin
                            w_emit = 1'b1;
                            if (w_del_bad) begin
                                n_out.status = pli_pkg::ST_BAD_POS;
                            end else begin
                                w_lop   = L_DEL;
                                n_count = r_count - pli_pkg::t_cnt'(1);
                            end
                        end
                        default: begin
                            w_lop   = L_CMP;
                            n_state = S_SRCH1;
                        end
                    endcase
                end
            end
            S_SRCH1: n_state = S_SRCH2;
            S_SRCH2: n_state = S_SRCH3;
            S_SRCH3: begin
                if (w_out_free) begin
                    w_emit        = 1'b1;
                    n_out.element = '0;
                    n_out.last    = 1'b1;
                    if (w_found) begin
                        n_out.status   = pli_pkg::ST_OK;
                        n_out.found_at = pli_pkg::t_pos'(w_found_idx) + 7'd1;
                    end else begin
                        n_out.status   = pli_pkg::ST_NOT_FOUND;
                        n_out.found_at = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                if (w_out_free) begin
                    w_emit         = 1'b1;
                    w_lop          = L_ROT;
                    n_out.status   = pli_pkg::ST_OK;
                    n_out.element  = pli_pkg::t_word'(w_data[0]);
                    n_out.found_at = '0;
                    n_out.last     = (r_left == pli_pkg::t_cnt'(1));
                    n_left         = r_left - pli_pkg::t_cnt'(1);
                    if (r_left == pli_pkg::t_cnt'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out.entry_count = pli_pkg::t_pos'(n_count);
        n_out_valid       = w_emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // per-cell control from the list operation
    always_comb begin
        for (int i = 0; i < pli_pkg::CAPACITY; i++) begin
            w_ctl[i].op  = pli_pkg::CELL_HOLD;
            w_ctl[i].cmp = 1'b0;
            case (w_lop)
                L_INS: begin
                    if (pli_pkg::t_cmp'(i) + pli_pkg::t_cmp'(1) == w_pos) begin
                        w_ctl[i].op = pli_pkg::CELL_LOAD;
                    end else if (pli_pkg::t_cmp'(i) >= w_pos &&
                                 pli_pkg::t_cmp'(i) <= w_cnt) begin
                        w_ctl[i].op = pli_pkg::CELL_FROM_LEFT;
                    end
                end
                L_DEL: begin
                    if (pli_pkg::t_cmp'(i) + pli_pkg::t_cmp'(1) >= w_pos &&
                        pli_pkg::t_cmp'(i) + pli_pkg::t_cmp'(1) < w_cnt) begin
                        w_ctl[i].op = pli_pkg::CELL_FROM_RIGHT;
                    end
                end
                L_ROT: begin
                    if (pli_pkg::t_cmp'(i) + pli_pkg::t_cmp'(1) < w_cnt) begin
                        w_ctl[i].op = pli_pkg::CELL_FROM_RIGHT;
                    end else if (pli_pkg::t_cmp'(i) + pli_pkg::t_cmp'(1) == w_cnt) begin
                        w_ctl[i].op = pli_pkg::CELL_LOAD;
                    end
                end
                L_CMP: begin
                    w_ctl[i].cmp = (pli_pkg::t_cmp'(i) < w_cnt);
                end
                default: begin
                    w_ctl[i].op = pli_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // the chain
    for (genvar i = 0; i < pli_pkg::CAPACITY; i++) begin : g_cell
        pli_pkg::t_data w_left;
        pli_pkg::t_data w_right;

        if (i == 0) begin : g_head
            assign w_left = w_data[i];
        end else begin : g_body_l
            assign w_left = w_data[i-1];
        end

        if (i == pli_pkg::CAPACITY - 1) begin : g_tail
            assign w_right = w_data[i];
        end else begin : g_body_r
            assign w_right = w_data[i+1];
        end

        pli_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (w_load),
            .i_key   (w_key),
            .o_data  (w_data[i]),
            .o_match (w_match[i])
        );
    end

    pli_first u_first (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_found (w_found),
        .o_idx   (w_found_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/pli_cell.sv
// one list cell: holds an entry, moves it along the chain, compares it with the key
module pli_cell (
    input  logic               i_clk,
    input  pli_pkg::t_cell_ctl i_ctl,
    input  pli_pkg::t_data     i_left,
    input  pli_pkg::t_data     i_right,
    input  pli_pkg::t_data     i_load,
    input  pli_pkg::t_data     i_key,
    output pli_pkg::t_data     o_data,
    output logic               o_match
);

    pli_pkg::t_data r_data;
    pli_pkg::t_data n_data;
    logic           r_match;

    always_comb begin
        case (i_ctl.op)
            pli_pkg::CELL_FROM_LEFT:  n_data = i_left;
            pli_pkg::CELL_FROM_RIGHT: n_data = i_right;
            pli_pkg::CELL_LOAD:       n_data = i_load;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= i_ctl.cmp && (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### rtl/pli_first.sv
// two-stage first-match encoder over the cell match flags
module pli_first (
    input  logic                          i_clk,
    input  logic [pli_pkg::CAPACITY-1:0]  i_match,
    output logic                          o_found,
    output pli_pkg::t_idx                 o_idx
);

    logic [pli_pkg::GRP_N*pli_pkg::GRP_W-1:0] w_pad;
    logic [pli_pkg::GRP_N-1:0]                n_grp_hit;
    pli_pkg::t_gidx                           n_grp_idx [pli_pkg::GRP_N];
    logic [pli_pkg::GRP_N-1:0]                r_grp_hit;
    pli_pkg::t_gidx                           r_grp_idx [pli_pkg::GRP_N];
    logic                                     n_found;
    pli_pkg::t_idx                            n_idx;
    logic                                     r_found;
    pli_pkg::t_idx                            r_idx;

    assign w_pad = (pli_pkg::GRP_N*pli_pkg::GRP_W)'(i_match);

    // stage one: lowest set flag inside each group
    always_comb begin
        for (int g = 0; g < pli_pkg::GRP_N; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int j = pli_pkg::GRP_W - 1; j >= 0; j--) begin
                if (w_pad[g*pli_pkg::GRP_W + j]) begin
                    n_grp_hit[g] = 1'b1;
                    n_grp_idx[g] = pli_pkg::t_gidx'(j);
                end
            end
        end
    end

    // stage two: lowest group with a hit
    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        for (int g = pli_pkg::GRP_N - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                n_found = 1'b1;
                n_idx   = pli_pkg::t_idx'(g*pli_pkg::GRP_W + int'(r_grp_idx[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        r_grp_idx <= n_grp_idx;
        r_found   <= n_found;
        r_idx     <= n_idx;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule
